@@ sv/assert_macros.svh @@
// assertion helpers for the pose update block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define VMPU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression must never be true outside reset
`define VMPU_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ sv/vmpu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vmpu_pkg;

    localparam int POSITION_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH_DEF    = 16;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_IW    = $clog2(CORDIC_STEPS);
    localparam int CW           = 34;   // cordic x/y, Q2.30 with headroom
    localparam int ZW           = 33;   // cordic residual angle
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam int MW   = 36;           // serial multiplier operand width
    localparam int DVW  = 34;           // dividend width
    localparam int DVDW = 16;           // divisor width
    localparam int DXW  = 36;           // displacement width
    localparam int NMW  = 50;           // numerator magnitude width
    localparam int LIMW = 15;           // straight limit register width

    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    function automatic logic [29:0] atan_turn(input logic [CORDIC_IW-1:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:    r = 30'd536870912;
            5'd1:    r = 30'd316933406;
            5'd2:    r = 30'd167458907;
            5'd3:    r = 30'd85004756;
            5'd4:    r = 30'd42667331;
            5'd5:    r = 30'd21354465;
            5'd6:    r = 30'd10679838;
            5'd7:    r = 30'd5340245;
            5'd8:    r = 30'd2670163;
            5'd9:    r = 30'd1335087;
            5'd10:   r = 30'd667544;
            5'd11:   r = 30'd333772;
            5'd12:   r = 30'd166886;
            5'd13:   r = 30'd83443;
            5'd14:   r = 30'd41722;
            5'd15:   r = 30'd20861;
            5'd16:   r = 30'd10430;
            5'd17:   r = 30'd5215;
            5'd18:   r = 30'd2608;
            5'd19:   r = 30'd1304;
            5'd20:   r = 30'd652;
            5'd21:   r = 30'd326;
            5'd22:   r = 30'd163;
            5'd23:   r = 30'd81;
            5'd24:   r = 30'd41;
            5'd25:   r = 30'd20;
            5'd26:   r = 30'd10;
            5'd27:   r = 30'd5;
            5'd28:   r = 30'd3;
            5'd29:   r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    typedef enum logic [2:0] {
        MS_VDT_COS,
        MS_VDT_SIN,
        MS_STEP,
        MS_NUM_X,
        MS_NUM_Y
    } t_mul_sel;

    typedef enum logic [3:0] {
        SV_NONE,
        SV_LOAD,
        SV_PREP,
        SV_SC0,
        SV_SC1,
        SV_DXS,
        SV_DYS,
        SV_STEP,
        SV_NUM,
        SV_DXD,
        SV_DYD,
        SV_FIN1,
        SV_FIN2
    } t_save;

    typedef struct packed {
        logic     capture;
        logic     cor_start;
        logic     cor_th1;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     div_start;
        t_save    save;
        logic     push;
    } t_cmd;

    typedef struct packed {
        logic is_move;
        logic straight;
        logic cor_done;
        logic mul_done;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ sv/vmpu_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vmpu_cordic import vmpu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_angle,
    output logic                 o_done,
    output logic signed [CW-1:0] o_sin,
    output logic signed [CW-1:0] o_cos
);

    localparam logic [CORDIC_IW-1:0] LAST = CORDIC_IW'(CORDIC_STEPS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CORDIC_IW-1:0] r_iter;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic [1:0]           r_quad;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] atan_z;
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [ZW-1:0] n_z;

    always_comb begin
        xs     = r_x >>> r_iter;
        ys     = r_y >>> r_iter;
        atan_z = $signed({{(ZW-30){1'b0}}, atan_turn(r_iter)});
        if (!r_z[ZW-1]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - atan_z;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + atan_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= $signed({{(ZW-30){1'b0}}, i_angle[29:0]});
            r_quad <= i_angle[31:30];
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    // fold the first-quadrant result out to the full circle
    always_comb begin
        case (r_quad)
            2'd0: begin
                o_cos = r_x;
                o_sin = r_y;
            end
            2'd1: begin
                o_cos = -r_y;
                o_sin = r_x;
            end
            2'd2: begin
                o_cos = -r_x;
                o_sin = -r_y;
            end
            default: begin
                o_cos = r_y;
                o_sin = -r_x;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

@@ sv/vmpu_muldiv.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vmpu_muldiv import vmpu_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_mul_start,
    input  logic signed [MW-1:0]   i_mul_a,
    input  logic signed [MW-1:0]   i_mul_b,
    output logic                   o_mul_done,
    output logic signed [2*MW-1:0] o_mul_prod,
    input  logic                   i_div_start,
    input  logic [DVW-1:0]         i_dividend,
    input  logic [DVDW-1:0]        i_divisor,
    output logic                   o_div_done,
    output logic [DVW-1:0]         o_quot
);

    localparam int MCW = $clog2(MW + 1);
    localparam int DCW = $clog2(DVW + 1);

    // shift-add multiplier on magnitudes, one operand bit a cycle
    logic            r_mbusy;
    logic            r_mdone;
    logic [MCW-1:0]  r_mcnt;
    logic [MW-1:0]   r_ma;
    logic [MW-1:0]   r_mb;
    logic [2*MW-1:0] r_acc;
    logic            r_mneg;

    logic [MW-1:0]   a_mag;
    logic [MW-1:0]   b_mag;
    logic [MW:0]     msum;

    assign a_mag = i_mul_a[MW-1] ? MW'(-i_mul_a) : MW'(i_mul_a);
    assign b_mag = i_mul_b[MW-1] ? MW'(-i_mul_b) : MW'(i_mul_b);
    assign msum  = {1'b0, r_acc[2*MW-1:MW]} + (r_mb[0] ? {1'b0, r_ma} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_mdone <= 1'b0;
            if (i_mul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= MCW'(MW);
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt - 1'b1;
                if (r_mcnt == MCW'(1)) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mul_start) begin
            r_ma   <= a_mag;
            r_mb   <= b_mag;
            r_acc  <= '0;
            r_mneg <= i_mul_a[MW-1] ^ i_mul_b[MW-1];
        end else if (r_mbusy) begin
            r_acc <= {msum, r_acc[MW-1:1]};
            r_mb  <= r_mb >> 1;
        end
    end

    assign o_mul_done = r_mdone;
    assign o_mul_prod = r_mneg ? -$signed(r_acc) : $signed(r_acc);

    // restoring divider, one quotient bit a cycle
    logic            r_dbusy;
    logic            r_ddone;
    logic [DCW-1:0]  r_dcnt;
    logic [DVDW-1:0] r_rem;
    logic [DVW-1:0]  r_q;
    logic [DVDW-1:0] r_d;

    logic [DVDW:0]   shifted;
    logic [DVDW:0]   trial;

    assign shifted = {r_rem, r_q[DVW-1]};
    assign trial   = shifted - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_ddone <= 1'b0;
            if (i_div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= DCW'(DVW);
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == DCW'(1)) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_div_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_dbusy) begin
            if (shifted >= {1'b0, r_d}) begin
                r_rem <= trial[DVDW-1:0];
                r_q   <= {r_q[DVW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DVDW-1:0];
                r_q   <= {r_q[DVW-2:0], 1'b0};
            end
        end
    end

    assign o_div_done = r_ddone;
    assign o_quot     = r_q;

endmodule

`default_nettype wire

@@ sv/vmpu_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vmpu_datapath import vmpu_pkg::*; #(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_cmd                             i_cmd,
    output t_stat                            o_stat,
    input  logic                             i_opcode,
    input  logic signed [15:0]               i_lin_velocity,
    input  logic signed [15:0]               i_turn_rate,
    input  logic [15:0]                      i_time_step,
    input  logic signed [31:0]               i_noise_east,
    input  logic signed [31:0]               i_noise_north,
    input  logic signed [15:0]               i_noise_heading,
    input  logic signed [31:0]               i_load_x,
    input  logic signed [31:0]               i_load_y,
    input  logic [15:0]                      i_load_heading,
    input  logic                             i_cfg_valid,
    input  logic [LIMW-1:0]                  i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [POSITION_WIDTH-1:0] o_pose_x,
    output logic signed [POSITION_WIDTH-1:0] o_pose_y,
    output logic [ANGLE_WIDTH-1:0]           o_pose_heading
);

    localparam int PW  = POSITION_WIDTH;
    localparam int AW  = ANGLE_WIDTH;
    localparam int SW  = ((PW > DXW) ? PW : DXW) + 2;
    localparam int PRW = 2 * MW;
    localparam int SH  = 60 - AW;

    // captured item
    logic               r_op;
    logic signed [15:0] r_v;
    logic signed [15:0] r_w;
    logic [15:0]        r_dt;
    logic signed [31:0] r_ne;
    logic signed [31:0] r_nn;
    logic signed [15:0] r_nh;
    logic signed [31:0] r_lx;
    logic signed [31:0] r_ly;
    logic [15:0]        r_lh;

    // pose and config
    logic signed [PW-1:0] r_east;
    logic signed [PW-1:0] r_north;
    logic [AW-1:0]        r_head;
    logic [LIMW-1:0]      r_limit;

    // working values
    logic signed [31:0]   r_vdt;
    logic signed [31:0]   r_wdt;
    logic                 r_straight;
    logic signed [CW-1:0] r_s0;
    logic signed [CW-1:0] r_c0;
    logic signed [CW-1:0] r_s1;
    logic signed [CW-1:0] r_c1;
    logic [AW-1:0]        r_th1;
    logic [DVW-1:0]       r_dvd;
    logic                 r_dneg;
    logic signed [DXW-1:0] r_dx;
    logic signed [DXW-1:0] r_dy;

    // result register
    logic                 r_ovalid;
    logic signed [PW-1:0] r_ox;
    logic signed [PW-1:0] r_oy;
    logic [AW-1:0]        r_oh;

    logic [15:0]           abs_w;
    logic signed [33:0]    vdt_full;
    logic signed [33:0]    wdt_full;
    logic                  straight_n;
    logic [AW-1:0]         cor_ang;
    logic [31:0]           cor_a32;
    logic                  cor_done;
    logic signed [CW-1:0]  cor_sin;
    logic signed [CW-1:0]  cor_cos;
    logic signed [MW-1:0]  mul_a;
    logic signed [MW-1:0]  mul_b;
    logic                  mul_done;
    logic signed [PRW-1:0] prod;
    logic                  div_done;
    logic [DVW-1:0]        quot;
    logic signed [PRW-1:0] rnd_str;
    logic signed [PRW-1:0] rnd_step;
    logic signed [PRW-1:0] rsh_str;
    logic signed [PRW-1:0] rsh_step;
    logic signed [DXW-1:0] dx_str;
    logic [AW-1:0]         step;
    logic [NMW-1:0]        num_mag;
    logic [NMW-1:0]        num_rnd;
    logic signed [DXW-1:0] q_s;
    logic signed [DXW-1:0] dx_div;
    logic signed [SW-1:0]  sum_e;
    logic signed [SW-1:0]  sum_n;
    logic [AW-1:0]         nh_a;
    logic [AW-1:0]         lh_a;

    function automatic logic signed [PW-1:0] sat_pos(input logic signed [SW-1:0] s);
        logic ovf;
        ovf = (s[SW-1:PW-1] != {(SW-PW+1){s[SW-1]}});
        if (ovf) begin
            return {s[SW-1], {(PW-1){~s[SW-1]}}};
        end
        return s[PW-1:0];
    endfunction

    assign abs_w      = r_w[15] ? 16'(-r_w) : 16'(r_w);
    assign vdt_full   = 34'(r_v) * $signed({18'b0, r_dt});
    assign wdt_full   = 34'(r_w) * $signed({18'b0, r_dt});
    // zero turn rate is always straight, even with a zero limit
    assign straight_n = (r_w == 16'sd0) || (abs_w < 16'(r_limit));

    assign cor_ang = i_cmd.cor_th1 ? r_th1 : r_head;
    assign cor_a32 = {cor_ang, {(32-AW){1'b0}}};

    vmpu_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cor_start),
        .i_angle (cor_a32),
        .o_done  (cor_done),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos)
    );

    always_comb begin
        case (i_cmd.mul_sel)
            MS_VDT_COS: begin
                mul_a = MW'(r_vdt);
                mul_b = MW'(r_c0);
            end
            MS_VDT_SIN: begin
                mul_a = MW'(r_vdt);
                mul_b = MW'(r_s0);
            end
            MS_STEP: begin
                mul_a = MW'(r_wdt);
                mul_b = $signed({{(MW-30){1'b0}}, INV_TWO_PI_Q32});
            end
            MS_NUM_X: begin
                mul_a = MW'(r_v);
                mul_b = MW'(r_s1) - MW'(r_s0);
            end
            MS_NUM_Y: begin
                mul_a = MW'(r_v);
                mul_b = MW'(r_c0) - MW'(r_c1);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    vmpu_muldiv u_muldiv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mul_start (i_cmd.mul_start),
        .i_mul_a     (mul_a),
        .i_mul_b     (mul_b),
        .o_mul_done  (mul_done),
        .o_mul_prod  (prod),
        .i_div_start (i_cmd.div_start),
        .i_dividend  (r_dvd),
        .i_divisor   (abs_w),
        .o_div_done  (div_done),
        .o_quot      (quot)
    );

    // round half up before the arithmetic shifts
    assign rnd_str  = prod + $signed({{(PRW-42){1'b0}}, 1'b1, 41'b0});
    assign rnd_step = prod + $signed({{(PRW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}});
    assign rsh_str  = rnd_str >>> 42;
    assign rsh_step = rnd_step >>> SH;
    assign dx_str   = rsh_str[DXW-1:0];
    assign step     = rsh_step[AW-1:0];

    // |num| / (|w| * 2^14) rounded half away: fold the 2^14 into the dividend
    assign num_mag = prod[PRW-1] ? NMW'(-prod) : NMW'(prod);
    assign num_rnd = num_mag + (NMW'(abs_w) << 13);
    assign q_s     = $signed(DXW'(quot));
    assign dx_div  = r_dneg ? -q_s : q_s;

    always_comb begin
        if (i_cmd.save == SV_FIN1) begin
            sum_e = SW'(r_east) + SW'(r_dx);
            sum_n = SW'(r_north) + SW'(r_dy);
        end else if (i_cmd.save == SV_FIN2) begin
            sum_e = SW'(r_east) + SW'(r_ne);
            sum_n = SW'(r_north) + SW'(r_nn);
        end else begin
            sum_e = SW'(r_lx);
            sum_n = SW'(r_ly);
        end
    end

    assign nh_a = AW'(r_nh);
    assign lh_a = AW'(r_lh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_east   <= '0;
            r_north  <= '0;
            r_head   <= '0;
            r_limit  <= LIMW'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            case (i_cmd.save)
                SV_LOAD: begin
                    r_east  <= sat_pos(sum_e);
                    r_north <= sat_pos(sum_n);
                    r_head  <= lh_a;
                end
                SV_FIN1: begin
                    r_east  <= sat_pos(sum_e);
                    r_north <= sat_pos(sum_n);
                    if (!r_straight) begin
                        r_head <= r_th1;
                    end
                end
                SV_FIN2: begin
                    r_east  <= sat_pos(sum_e);
                    r_north <= sat_pos(sum_n);
                    r_head  <= r_head + nh_a;
                end
                default: begin
                end
            endcase
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_opcode;
            r_v  <= i_lin_velocity;
            r_w  <= i_turn_rate;
            r_dt <= i_time_step;
            r_ne <= i_noise_east;
            r_nn <= i_noise_north;
            r_nh <= i_noise_heading;
            r_lx <= i_load_x;
            r_ly <= i_load_y;
            r_lh <= i_load_heading;
        end
        case (i_cmd.save)
            SV_PREP: begin
                r_vdt      <= vdt_full[31:0];
                r_wdt      <= wdt_full[31:0];
                r_straight <= straight_n;
            end
            SV_SC0: begin
                r_s0 <= cor_sin;
                r_c0 <= cor_cos;
            end
            SV_SC1: begin
                r_s1 <= cor_sin;
                r_c1 <= cor_cos;
            end
            SV_DXS:  r_dx  <= dx_str;
            SV_DYS:  r_dy  <= dx_str;
            SV_STEP: r_th1 <= r_head + step;
            SV_NUM: begin
                r_dvd  <= DVW'(num_rnd >> 14);
                r_dneg <= prod[PRW-1] ^ r_w[15];
            end
            SV_DXD:  r_dx <= dx_div;
            SV_DYD:  r_dy <= dx_div;
            default: begin
            end
        endcase
        if (i_cmd.push) begin
            r_ox <= r_east;
            r_oy <= r_north;
            r_oh <= r_head;
        end
    end

    assign o_stat.is_move  = r_op;
    assign o_stat.straight = r_straight;
    assign o_stat.cor_done = cor_done;
    assign o_stat.mul_done = mul_done;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_ovalid || i_ready;

    assign o_valid        = r_ovalid;
    assign o_pose_x       = r_ox;
    assign o_pose_y       = r_oy;
    assign o_pose_heading = r_oh;

endmodule

`default_nettype wire

@@ sv/vmpu_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vmpu_ctrl import vmpu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [21:0] {
        S_IDLE = 22'h000001,
        S_PREP = 22'h000002,
        S_C0W  = 22'h000004,
        S_MXG  = 22'h000008,
        S_MXW  = 22'h000010,
        S_MYG  = 22'h000020,
        S_MYW  = 22'h000040,
        S_MSG  = 22'h000080,
        S_MSW  = 22'h000100,
        S_C1G  = 22'h000200,
        S_C1W  = 22'h000400,
        S_NXG  = 22'h000800,
        S_NXW  = 22'h001000,
        S_DXG  = 22'h002000,
        S_DXW  = 22'h004000,
        S_NYG  = 22'h008000,
        S_NYW  = 22'h010000,
        S_DYG  = 22'h020000,
        S_DYW  = 22'h040000,
        S_FIN1 = 22'h080000,
        S_FIN2 = 22'h100000,
        S_PUSH = 22'h200000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = MS_VDT_COS;
        o_cmd.save    = SV_NONE;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                // no transfer is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                if (i_stat.is_move) begin
                    o_cmd.save      = SV_PREP;
                    o_cmd.cor_start = 1'b1;
                    n_state         = S_C0W;
                end else begin
                    o_cmd.save = SV_LOAD;
                    n_state    = S_PUSH;
                end
            end
            S_C0W: begin
                if (i_stat.cor_done) begin
                    o_cmd.save = SV_SC0;
                    n_state    = i_stat.straight ? S_MXG : S_MSG;
                end
            end
            // straight line
            S_MXG: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_VDT_COS;
                n_state         = S_MXW;
            end
            S_MXW: begin
                if (i_stat.mul_done) begin
                    o_cmd.save = SV_DXS;
                    n_state    = S_MYG;
                end
            end
            S_MYG: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_VDT_SIN;
                n_state         = S_MYW;
            end
            S_MYW: begin
                if (i_stat.mul_done) begin
                    o_cmd.save = SV_DYS;
                    n_state    = S_FIN1;
                end
            end
            // arc
            S_MSG: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_STEP;
                n_state         = S_MSW;
            end
            S_MSW: begin
                if (i_stat.mul_done) begin
                    o_cmd.save = SV_STEP;
                    n_state    = S_C1G;
                end
            end
            S_C1G: begin
                o_cmd.cor_start = 1'b1;
                o_cmd.cor_th1   = 1'b1;
                n_state         = S_C1W;
            end
            S_C1W: begin
                if (i_stat.cor_done) begin
                    o_cmd.save = SV_SC1;
                    n_state    = S_NXG;
                end
            end
            S_NXG: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_NUM_X;
                n_state         = S_NXW;
            end
            S_NXW: begin
                if (i_stat.mul_done) begin
                    o_cmd.save = SV_NUM;
                    n_state    = S_DXG;
                end
            end
            S_DXG: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DXW;
            end
            S_DXW: begin
                if (i_stat.div_done) begin
                    o_cmd.save = SV_DXD;
                    n_state    = S_NYG;
                end
            end
            S_NYG: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_NUM_Y;
                n_state         = S_NYW;
            end
            S_NYW: begin
                if (i_stat.mul_done) begin
                    o_cmd.save = SV_NUM;
                    n_state    = S_DYG;
                end
            end
            S_DYG: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DYW;
            end
            S_DYW: begin
                if (i_stat.div_done) begin
                    o_cmd.save = SV_DYD;
                    n_state    = S_FIN1;
                end
            end
            S_FIN1: begin
                o_cmd.save = SV_FIN1;
                n_state    = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.save = SV_FIN2;
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                // hold the new pose until the result register has room
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `VMPU_ASSERT(a_capture_blocks_input, i_clk, i_rst_n, o_cmd.capture |=> !o_in_ready, "retaken")
    `VMPU_ASSERT_NEVER(a_mul_div_overlap, i_clk, i_rst_n, o_cmd.mul_start && o_cmd.div_start, "overlap")
    `VMPU_ASSERT(a_push_needs_room, i_clk, i_rst_n, o_cmd.push |-> i_stat.out_free, "push over result")

endmodule

`default_nettype wire

@@ sv/velocity_motion_pose_update_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pose update for one robot pose (x, y, heading) under a velocity motion model.
// Input channel (i_valid/o_ready) carries one item: opcode 0 loads the pose from
// the load fields, opcode 1 applies a motion step with velocity, turn rate, time
// step and the three noise samples. Every item returns one pose on the output
// channel (o_valid/i_ready). The straight limit register is written over the
// config channel (i_cfg_valid/o_cfg_ready), which is ready whenever out of reset.
// One item is worked at a time. A straight step uses one 30-step cordic pass
// and two shift-add multiplies. An arc step uses two cordic passes, three
// multiplies and two restoring divides, all run on the single shared cordic,
// multiplier and divider.
// The result sits in an output register; the next item is taken while it waits,
// and the block only stalls at its final write if the receiver still holds the
// previous pose. Reset clears the pose to zero, sets the straight limit to 1 and
// empties the output register.
module velocity_motion_pose_update_unit import vmpu_pkg::*; #(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_opcode,
    input  logic signed [15:0]               i_lin_velocity,
    input  logic signed [15:0]               i_turn_rate,
    input  logic [15:0]                      i_time_step,
    input  logic signed [31:0]               i_noise_east,
    input  logic signed [31:0]               i_noise_north,
    input  logic signed [15:0]               i_noise_heading,
    input  logic signed [31:0]               i_load_x,
    input  logic signed [31:0]               i_load_y,
    input  logic [15:0]                      i_load_heading,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [LIMW-1:0]                  i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [POSITION_WIDTH-1:0] o_pose_x,
    output logic signed [POSITION_WIDTH-1:0] o_pose_y,
    output logic [ANGLE_WIDTH-1:0]           o_pose_heading
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = i_rst_n;

    vmpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_in_ready (o_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vmpu_datapath #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .ANGLE_WIDTH    (ANGLE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_opcode),
        .i_lin_velocity  (i_lin_velocity),
        .i_turn_rate     (i_turn_rate),
        .i_time_step     (i_time_step),
        .i_noise_east    (i_noise_east),
        .i_noise_north   (i_noise_north),
        .i_noise_heading (i_noise_heading),
        .i_load_x        (i_load_x),
        .i_load_y        (i_load_y),
        .i_load_heading  (i_load_heading),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pose_x        (o_pose_x),
        .o_pose_y        (o_pose_y),
        .o_pose_heading  (o_pose_heading)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import vmpu_pkg::*; ();

    localparam logic OP_SET_POSE = 1'b0;
    localparam logic OP_MOVE     = 1'b1;
    localparam int   ITEM_COUNT  = 1850;
    localparam int   QUIET_TAIL  = 150;

    typedef struct {
        logic               op;
        logic signed [15:0] vel;
        logic signed [15:0] turn;
        logic [15:0]        dt;
        logic signed [31:0] n_east;
        logic signed [31:0] n_north;
        logic signed [15:0] n_head;
        logic signed [31:0] ld_x;
        logic signed [31:0] ld_y;
        logic [15:0]        ld_head;
    } motion_item_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        h;
    } pose_t;

    class pose_scoreboard;
        longint      east_pos;
        longint      north_pos;
        logic [15:0] heading;
        logic [14:0] limit;
        pose_t       pending[$];
        int          errors;
        int          checked;
        int          n_line;
        int          n_arc;
        int          n_load;
        longint      atan_turns[30] = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
            41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
            10, 5, 3, 1};

        function new();
            east_pos  = 0;
            north_pos = 0;
            heading   = '0;
            limit     = 15'd1;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint round_shift(longint v, int n);
            return (v + (64'sd1 <<< (n - 1))) >>> n;
        endfunction

        // quotient rounded half away from zero
        function longint div_away(longint num, longint den);
            logic            neg;
            longint unsigned n;
            longint unsigned d;
            longint unsigned q;
            neg = (num < 0) != (den < 0);
            n = (num < 0) ? -num : num;
            d = (den < 0) ? -den : den;
            q = (n + d / 2) / d;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        // 30-step rotation on the 32-bit angle, outputs Q2.30
        function void sin_cos(logic [15:0] ang, output longint s, output longint c);
            logic [31:0] a32;
            longint      x;
            longint      y;
            longint      z;
            longint      xs;
            longint      ys;
            a32 = {ang, 16'h0};
            z = a32[29:0];
            x = 652032874;
            y = 0;
            for (int i = 0; i < 30; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= atan_turns[i];
                end else begin
                    x += ys; y -= xs; z += atan_turns[i];
                end
            end
            case (a32[31:30])
                2'd0:    begin c = x;  s = y;  end
                2'd1:    begin c = -y; s = x;  end
                2'd2:    begin c = -x; s = -y; end
                default: begin c = y;  s = -x; end
            endcase
        endfunction

        function void note_input(motion_item_t it);
            longint v;
            longint w;
            longint dt;
            longint s0;
            longint c0;
            longint s1;
            longint c1;
            longint dx;
            longint dy;
            longint step;
            logic [15:0] th1;
            pose_t p;
            if (it.op == OP_SET_POSE) begin
                east_pos  = it.ld_x;
                north_pos = it.ld_y;
                heading   = it.ld_head;
                n_load++;
            end else begin
                v  = it.vel;
                w  = it.turn;
                dt = it.dt;
                sin_cos(heading, s0, c0);
                if (w == 0 || (w < 0 ? -w : w) < longint'(limit)) begin
                    dx = round_shift(v * dt * c0, 42);
                    dy = round_shift(v * dt * s0, 42);
                    n_line++;
                end else begin
                    step = round_shift(w * dt * 64'sd683565276, 44);
                    th1 = heading + step[15:0];
                    sin_cos(th1, s1, c1);
                    dx = div_away(v * (s1 - s0), w * 16384);
                    dy = div_away(v * (c0 - c1), w * 16384);
                    heading = th1;
                    n_arc++;
                end
                east_pos  = sat32(sat32(east_pos + dx) + longint'(it.n_east));
                north_pos = sat32(sat32(north_pos + dy) + longint'(it.n_north));
                heading   = heading + it.n_head;
            end
            p.x = east_pos[31:0];
            p.y = north_pos[31:0];
            p.h = heading;
            pending.push_back(p);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
            errors++;
        endtask

        task check_pose(pose_t got);
            pose_t want;
            if (pending.size() == 0) begin
                $display("unexpected result %0d: no pose pending", checked);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got.x !== want.x) report_mismatch("pose_x", got.x, want.x);
                if (got.y !== want.y) report_mismatch("pose_y", got.y, want.y);
                if (got.h !== want.h) report_mismatch("pose_heading", got.h, want.h);
            end
            checked++;
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_opcode = 1'b0;
    logic signed [15:0] i_lin_velocity = '0;
    logic signed [15:0] i_turn_rate = '0;
    logic [15:0]        i_time_step = '0;
    logic signed [31:0] i_noise_east = '0;
    logic signed [31:0] i_noise_north = '0;
    logic signed [15:0] i_noise_heading = '0;
    logic signed [31:0] i_load_x = '0;
    logic signed [31:0] i_load_y = '0;
    logic [15:0]        i_load_heading = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [LIMW-1:0]    i_cfg_data = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_pose_x;
    logic signed [31:0] o_pose_y;
    logic [15:0]        o_pose_heading;

    pose_scoreboard sb = new();
    bit             quiet = 1'b0;
    int             stall_left = 0;
    int             sent = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    velocity_motion_pose_update_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_lin_velocity  (i_lin_velocity),
        .i_turn_rate     (i_turn_rate),
        .i_time_step     (i_time_step),
        .i_noise_east    (i_noise_east),
        .i_noise_north   (i_noise_north),
        .i_noise_heading (i_noise_heading),
        .i_load_x        (i_load_x),
        .i_load_y        (i_load_y),
        .i_load_heading  (i_load_heading),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pose_x        (o_pose_x),
        .o_pose_y        (o_pose_y),
        .o_pose_heading  (o_pose_heading)
    );

    // receiver back-pressure in bursts
    always @(negedge i_clk) begin
        if (quiet) begin
            i_ready = 1'b1;
        end else if (stall_left > 0) begin
            i_ready = 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            i_ready = 1'b0;
            stall_left = $urandom_range(0, 9);
        end else begin
            i_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        pose_t got;
        if (i_rst_n && o_valid && i_ready) begin
            got.x = o_pose_x;
            got.y = o_pose_y;
            got.h = o_pose_heading;
            sb.check_pose(got);
        end
    end

    function automatic motion_item_t mk_move(logic signed [15:0] v, logic signed [15:0] w,
                                             logic [15:0] dt, logic signed [31:0] ne,
                                             logic signed [31:0] nn, logic signed [15:0] nh);
        motion_item_t it;
        it = '{OP_MOVE, v, w, dt, ne, nn, nh, $urandom, $urandom,
               16'($urandom_range(0, 65535))};
        return it;
    endfunction

    function automatic motion_item_t mk_load(logic signed [31:0] x, logic signed [31:0] y,
                                             logic [15:0] h);
        motion_item_t it;
        it = '{OP_SET_POSE, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), $urandom, $urandom,
               16'($urandom_range(0, 65535)), x, y, h};
        return it;
    endfunction

    function automatic motion_item_t rand_item();
        motion_item_t it;
        int           lim;
        lim = (sb.limit == 0) ? 1 : sb.limit;
        if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 3) == 0)
                return mk_load($urandom, $urandom, 16'($urandom_range(0, 65535)));
            return mk_load($signed($urandom_range(0, 2**24)) - 2**23,
                           $signed($urandom_range(0, 2**24)) - 2**23,
                           16'($urandom_range(0, 65535)));
        end
        it = mk_move(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)),
                     $signed($urandom_range(0, 8191)) - 4096,
                     $signed($urandom_range(0, 8191)) - 4096,
                     16'($urandom_range(0, 65535)));
        case ($urandom_range(0, 5))
            0: it.turn = '0;
            1: it.turn = 16'($signed($urandom_range(0, 2 * lim)) - lim);
            2: it.dt = 16'($urandom_range(0, 2047));
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0) begin
            it.n_east  = $urandom;
            it.n_north = $urandom;
        end
        return it;
    endfunction

    task automatic send_item(motion_item_t it);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_opcode        = it.op;
        i_lin_velocity  = it.vel;
        i_turn_rate     = it.turn;
        i_time_step     = it.dt;
        i_noise_east    = it.n_east;
        i_noise_north   = it.n_north;
        i_noise_heading = it.n_head;
        i_load_x        = it.ld_x;
        i_load_y        = it.ld_y;
        i_load_heading  = it.ld_head;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(it);
        sent++;
        quiet = (sent > ITEM_COUNT - QUIET_TAIL);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.limit = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        logic [LIMW-1:0] limits[6];
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // first items run on the reset value of the limit
        send_item(mk_move(16'sd4096, 16'sd0, 16'hFFFF, 32'sd0, 32'sd0, 16'sd0));
        send_item(mk_move(16'sd4096, 16'sd1, 16'h8000, 32'sd0, 32'sd0, 16'sd0));
        drain();
        // limit zero: exactly zero turn rate must still move straight
        write_limit(15'd0);
        send_item(mk_load(32'sh7FFFFFFF, -32'sh80000000, 16'hFFFF));
        send_item(mk_move(16'sh7FFF, 16'sd0, 16'hFFFF, 32'sd0, 32'sd0, 16'sd0));
        send_item(mk_move(16'sd3000, 16'sd1, 16'h4000, 32'sd0, 32'sd0, 16'sd0));
        send_item(mk_load(32'sd0, 32'sd0, 16'h0));
        send_item(mk_move(-16'sh8000, 16'sh7FFF, 16'hFFFF, 32'sd0, 32'sd0, 16'sd0));
        send_item(mk_move(16'sh7FFF, -16'sh8000, 16'hFFFF, 32'sd0, 32'sd0, 16'sd0));
        send_item(mk_move(16'sh7FFF, 16'sh7FFF, 16'h0000, 32'sd0, 32'sd0, 16'sd0));
        send_item(mk_move(16'sd0, -16'sd100, 16'hFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                          16'sh7FFF));
        send_item(mk_move(16'sh7FFF, 16'sd0, 16'hFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                          16'sd0));
        send_item(mk_move(-16'sh8000, 16'sd0, 16'hFFFF, -32'sh80000000, -32'sh80000000,
                          -16'sh8000));
        send_item(mk_move(-16'sh8000, 16'sd0, 16'hFFFF, -32'sh80000000, -32'sh80000000,
                          16'sd0));
        send_item(mk_load(-32'sh80000000, 32'sh7FFFFFFF, 16'h8000));
        send_item(mk_move(-16'sh8000, 16'sd2000, 16'hFFFF, 32'sd0, 32'sd0, 16'sd0));
        drain();
        // full-scale limit: +max turn rate sits on the boundary and still arcs
        write_limit(15'h7FFF);
        send_item(mk_load(32'sd0, 32'sd0, 16'h4000));
        send_item(mk_move(16'sd4096, 16'sh7FFE, 16'h1000, 32'sd0, 32'sd0, 16'sd0));
        send_item(mk_move(16'sd4096, 16'sh7FFF, 16'h1000, 32'sd0, 32'sd0, 16'sd0));
        send_item(mk_move(16'sd4096, -16'sh7FFF, 16'h1000, 32'sd0, 32'sd0, 16'sd0));
        send_item(mk_move(16'sd4096, -16'sh8000, 16'h1000, -32'sd1, 32'sd1, -16'sd1));
        drain();

        limits = '{15'd1, 15'd0, 15'h7FFF, 15'($urandom_range(0, 32767)), 15'd200,
                   15'($urandom_range(0, 8191))};
        foreach (limits[p]) begin
            write_limit(limits[p]);
            while (sent < 21 + (p + 1) * (ITEM_COUNT - 21) / 6)
                send_item(rand_item());
            drain();
        end

        repeat (300) @(posedge i_clk);
        $display("covered %0d set-pose, %0d straight and %0d arc steps over %0d limit settings",
                 sb.n_load, sb.n_line, sb.n_arc, 9);
        $display("%0d poses compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("timeout with %0d poses outstanding", sb.pending.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/vmpu_pkg.sv
sv/vmpu_cordic.sv
sv/vmpu_muldiv.sv
sv/vmpu_datapath.sv
sv/vmpu_ctrl.sv
sv/velocity_motion_pose_update_unit.sv
tb/sv/tb_top.sv
